// File: hdl/moving_average_filter_defines.svh
// ----------------------------------------------------------------------------
// moving_average_filter_defines
// Assertion macros for the moving average filter.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MAF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MAF_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MAF_ASSERT(label, clk, rst, prop, msg)
`define MAF_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// File: hdl/mavg_pkg.sv
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared widths, register indexes and state types of the moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_LEN_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE    = 2'd1;

  localparam logic [CFG_LEN_W-1:0]       RESET_WINDOW_LENGTH = 7'd8;
  localparam logic signed [SAMPLE_W-1:0] RESET_INIT_VALUE    = 16'sd0;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_UPD  = 2'b10
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RUN  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

// File: hdl/mavg_fifo.sv
// ----------------------------------------------------------------------------
// mavg_fifo
// Two-entry queue of window sums between the front and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_fifo #(
  parameter int WIDTH = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/mavg_front.sv
// ----------------------------------------------------------------------------
// mavg_front
// Configuration registers, sample ring and running window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_front #(
  parameter int MAX_WINDOW = 64,
  parameter int LEN_W      = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W      = mavg_pkg::SAMPLE_W + $clog2(MAX_WINDOW)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mavg_pkg::SAMPLE_W-1:0]     s_tdata,
  output logic [LEN_W-1:0]                  eff_len,
  output logic                              push,
  output logic [SUM_W-1:0]                  push_data,
  input  logic                              q_full
);

  import mavg_pkg::*;

  localparam int SLOT_W = $clog2(MAX_WINDOW);

  logic [CFG_LEN_W-1:0]       window_length;
  logic signed [SAMPLE_W-1:0] init_value;
  logic                       refill;
  logic [SLOT_W-1:0]          slot;
  logic                       wrapped;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_next;
  logic signed [SAMPLE_W-1:0] sample_hold;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0]        ring [MAX_WINDOW];
  front_state_t               state;
  logic [31:0]                len_wide;
  logic [LEN_W-1:0]           slot_inc;
  logic                       last_slot;
  logic                       accept;
  logic                       cfg_hit;
  logic signed [SAMPLE_W+LEN_W:0] refill_prod;

  always_comb begin
    if (window_length == '0) begin
      len_wide = 32'd1;
    end else if (32'(window_length) > MAX_WINDOW) begin
      len_wide = 32'(MAX_WINDOW);
    end else begin
      len_wide = 32'(window_length);
    end
  end

  assign eff_len     = len_wide[LEN_W-1:0];
  assign refill_prod = $signed({1'b0, eff_len}) * init_value;
  assign s_tready    = (state == F_IDLE) && !refill;
  assign accept      = s_tvalid && s_tready;
  assign cfg_hit     = cfg_we && ((cfg_index == REG_WINDOW_LENGTH) ||
                                  (cfg_index == REG_INIT_VALUE));
  assign old_sample  = wrapped ? rd_data : init_value;
  assign sum_next    = sum + SUM_W'(sample_hold) - SUM_W'(old_sample);
  assign push        = (state == F_UPD) && !q_full;
  assign push_data   = sum_next;
  assign slot_inc    = LEN_W'(slot) + 1'b1;
  assign last_slot   = slot_inc == eff_len;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data     <= ring[slot];
      sample_hold <= s_tdata;
    end
    if (push) begin
      ring[slot] <= sample_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= RESET_WINDOW_LENGTH;
      init_value    <= RESET_INIT_VALUE;
      refill        <= 1'b1;
      slot          <= '0;
      wrapped       <= 1'b0;
      sum           <= '0;
      state         <= F_IDLE;
    end else begin
      if (cfg_hit) begin
        if (cfg_index == REG_WINDOW_LENGTH) begin
          window_length <= cfg_data[CFG_LEN_W-1:0];
        end else begin
          init_value <= cfg_data;
        end
        refill  <= 1'b1;
        slot    <= '0;
        wrapped <= 1'b0;
      end else if (refill) begin
        sum    <= SUM_W'(refill_prod);
        refill <= 1'b0;
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_UPD;
          end
        end
        F_UPD: begin
          if (push) begin
            sum   <= sum_next;
            state <= F_IDLE;
            if (last_slot) begin
              slot    <= '0;
              wrapped <= 1'b1;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/mavg_div.sv
// ----------------------------------------------------------------------------
// mavg_div
// Bit-serial signed divide of the window sum by the window length.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
  parameter int LEN_W = 7,
  parameter int SUM_W = 22
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [LEN_W-1:0]              eff_len,
  input  logic                          q_empty,
  input  logic [SUM_W-1:0]              q_data,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mavg_pkg::SAMPLE_W-1:0] m_tdata
);

  import mavg_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  back_state_t          state;
  logic [SUM_W-1:0]     dividend;
  logic [LEN_W-1:0]     rem;
  logic [CNT_W-1:0]     count;
  logic                 neg;
  logic [LEN_W:0]       trial;
  logic                 qbit;
  logic                 load;
  logic [SAMPLE_W-1:0]  quot;

  assign pop   = (state == B_IDLE) && !q_empty;
  assign trial = {rem, dividend[SUM_W-1]};
  assign qbit  = trial >= {1'b0, eff_len};
  assign load  = (state == B_DONE) && (!m_tvalid || m_tready);
  assign quot  = dividend[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          neg      <= q_data[SUM_W-1];
          dividend <= q_data[SUM_W-1] ? (~q_data + 1'b1) : q_data;
          rem      <= '0;
          count    <= CNT_W'(SUM_W - 1);
        end
      end
      B_RUN: begin
        rem      <= qbit ? LEN_W'(trial - {1'b0, eff_len}) : trial[LEN_W-1:0];
        dividend <= {dividend[SUM_W-2:0], qbit};
        count    <= count - 1'b1;
      end
      default: begin
      end
    endcase
    if (load) begin
      m_tdata <= neg ? (~quot + 1'b1) : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (count == '0) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average of signed 16-bit samples, mean truncated toward zero.
//
//   channel   dir  beat content (lsb up)
//   s_axis    in   s_tdata: sample[15:0]
//   m_axis    out  m_tdata: average[15:0]
//   cfg       in   cfg_index 0 window_length[6:0], 1 init_value[15:0]
//
// Front: ring read, then sum update and ring write; the update waits while
// the queue is full, and no new sample is taken until it is done.
// Divider: one quotient bit per cycle; it takes one sum at a time and sets
// the sustained sample rate. After reset and after each write to index 0 or
// 1 the window refills, with s_tready low. A two-entry queue lets the front
// run ahead of a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_filter_defines.svh"

module moving_average_filter #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mavg_pkg::SAMPLE_W-1:0]   s_tdata,   // sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mavg_pkg::SAMPLE_W-1:0]   m_tdata,   // average
  input  logic                            cfg_we,
  input  logic [mavg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mavg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import mavg_pkg::*;

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  logic [LEN_W-1:0] eff_len;
  logic             push;
  logic [SUM_W-1:0] push_data;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  logic [SUM_W-1:0] pop_data;

  mavg_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .LEN_W      (LEN_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .eff_len   (eff_len),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  mavg_fifo #(
    .WIDTH (SUM_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  mavg_div #(
    .LEN_W (LEN_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .eff_len  (eff_len),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `MAF_NEVER(a_no_push_full, clk, rst, push && q_full, "push into full queue")
  `MAF_NEVER(a_no_pop_empty, clk, rst, pop && q_empty, "pop from empty queue")
  `MAF_ASSERT(a_front_busy, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "front took two beats")

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boxcar moving average filter. A directed table
// covers the reset window, the extremes of the sample range, zero and
// oversized window lengths, ignored register indexes and refills on writes.
// Random sample phases follow, each after random register writes. Each
// average is compared with its table value or a running-sum bench window.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mavg_pkg::*;

  localparam int DEPTH = 64;
  localparam int RANDOM_SAMPLES = 600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic {DO_SAMPLE, DO_WRITE} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           value;
    bit                    typed;
    logic [15:0]           want;
  } plan_row_t;

  localparam int PLAN_ROWS = 28;

  plan_row_t plan [PLAN_ROWS] = '{
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h0000, 1'b1, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF, 1'b1, 16'd4095},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b1, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'hFFFF, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_WINDOW_LENGTH, 16'h0001, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF, 1'b1, 16'h7FFF},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b1, 16'h8000},
    '{DO_WRITE,  REG_WINDOW_LENGTH, 16'h0000, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'd12345, 1'b1, 16'd12345},
    '{DO_WRITE,  REG_INIT_VALUE,    16'h8000, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_WINDOW_LENGTH, 16'hFF7F, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b1, 16'h8000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_SPARE_2,       16'h1234, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_SPARE_3,       16'hFFFF, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h0000, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_INIT_VALUE,    16'h7FFF, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h7FFF, 1'b1, 16'h7FFF},
    '{DO_WRITE,  REG_WINDOW_LENGTH, 16'h0040, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_WINDOW_LENGTH, 16'h0003, 1'b0, 16'h0000},
    '{DO_WRITE,  REG_INIT_VALUE,    16'hFFFB, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'hFFFB, 1'b1, 16'hFFFB},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h0000, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h0007, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h0007, 1'b0, 16'h0000},
    '{DO_SAMPLE, REG_WINDOW_LENGTH, 16'h8000, 1'b0, 16'h0000}
  };

  logic [6:0] len_extremes [7] = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd65, 7'd127};

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata;   // sample[15:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;   // average[15:0]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic                  quiet = 1'b0;
  int                    errors = 0;
  logic [15:0]           pending_means [$];

  // window model
  logic [6:0]            len_reg;
  logic signed [15:0]    init_reg;
  logic signed [15:0]    win_ring [DEPTH];
  int unsigned           win_slot;
  longint                win_sum;

  moving_average_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned span();
    if (len_reg == 7'd0) begin
      return 1;
    end
    if (len_reg > DEPTH) begin
      return DEPTH;
    end
    return 32'(len_reg);
  endfunction

  function automatic void window_refill();
    for (int i = 0; i < DEPTH; i++) begin
      win_ring[i] = init_reg;
    end
    win_slot = 0;
    win_sum = longint'(init_reg) * longint'(span());
  endfunction

  function automatic logic [15:0] window_mean(input logic signed [15:0] s);
    int unsigned n;
    int unsigned slot;
    longint q;
    n = span();
    slot = win_slot;
    if (slot >= n) begin
      slot = 0;
    end
    win_sum = win_sum + longint'(s) - longint'(win_ring[slot]);
    win_ring[slot] = s;
    slot++;
    if (slot >= n) begin
      slot = 0;
    end
    win_slot = slot;
    q = win_sum / longint'(n);
    return q[15:0];
  endfunction

  function automatic logic [15:0] draw_sample();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      7: begin
        return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      end
      8: begin
        return init_reg;
      end
      9: begin
        return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    if (errors <= 50) begin
      $display("%0t %s: got %0d expected %0d", $realtime, what, $signed(got), $signed(want));
    end
  endtask

  // drop valid and hold until every average has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_means.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH: begin
        len_reg = value[6:0];
        window_refill();
      end
      REG_INIT_VALUE: begin
        init_reg = value;
        window_refill();
      end
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic send(input logic [15:0] s, input bit typed, input logic [15:0] want);
    logic [15:0] mean;
    while (!quiet && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= s;
    do begin
      @(posedge clk);
    end while (!s_tready);
    mean = window_mean(s);
    pending_means.push_back(typed ? want : mean);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_means.size() == 0) begin
        report("average beat with nothing expected", m_tdata, 16'h0000);
      end else begin
        if (m_tdata !== pending_means[0]) begin
          report("average mismatch", m_tdata, pending_means[0]);
        end
        void'(pending_means.pop_front());
      end
    end
  end

  initial begin
    int sent;
    int phase_len;
    int unsigned pick;
    logic [6:0] len_val;
    logic [15:0] fill_val;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    len_reg = RESET_WINDOW_LENGTH;
    init_reg = RESET_INIT_VALUE;
    window_refill();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == DO_WRITE) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send(plan[i].value, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      wait_idle();
      pick = $urandom_range(3);
      len_val = $urandom_range(1) ? len_extremes[$urandom_range(6)] : 7'($urandom_range(127));
      fill_val = $urandom_range(1) ? 16'($urandom) : ($urandom_range(1) ? 16'h7FFF : 16'h8000);
      if (pick == 0 || pick == 2) begin
        write_reg(REG_WINDOW_LENGTH, {9'($urandom), len_val});
      end
      if (pick == 1 || pick == 2) begin
        write_reg(REG_INIT_VALUE, fill_val);
      end
      if (pick == 3) begin
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 16'($urandom));
      end
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        quiet = (sent >= 250 && sent < 350);
        if (sent == 150) begin
          wait_idle();
        end
        send(draw_sample(), 1'b0, 16'h0000);
        sent++;
      end
    end
    quiet = 1'b0;

    wait_idle();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/mavg_pkg.sv
hdl/mavg_fifo.sv
hdl/mavg_front.sv
hdl/mavg_div.sv
hdl/moving_average_filter.sv
dv/tb.sv
